[rtl/upip_pkg.sv]
// Shared types and constants of the unsteady panel influence phase block.
package upip_pkg;

    localparam int RAD_W  = 68;
    localparam int REM_W  = 36;
    localparam int ROOT_W = 34;
    localparam int CXY_W  = 34;
    localparam int CZ_W   = 33;
    localparam int MAX_CORDIC = 32;

    localparam logic [1:0] CFG_OMEGA = 2'd0;
    localparam logic [1:0] CFG_MACH  = 2'd1;

    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    localparam logic signed [CXY_W-1:0] CORDIC_INIT_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [0:MAX_CORDIC-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic               func;
        logic signed [31:0] ctrl_x;
        logic signed [31:0] ctrl_y;
        logic signed [31:0] ctrl_z;
        logic signed [31:0] panel_x;
        logic signed [31:0] panel_y;
        logic signed [31:0] panel_z;
        logic signed [15:0] normal_x;
        logic signed [31:0] steady_source;
        logic signed [31:0] steady_doublet;
        logic               last_pair;
    } t_in;

    typedef struct packed {
        logic signed [31:0] src_real;
        logic signed [31:0] src_imag;
        logic signed [31:0] dbl_real;
        logic signed [31:0] dbl_imag;
        logic               last;
    } t_out;

endpackage

[rtl/upip_sqrt_cell.sv]
// One digit cell of the pipelined square root chain.
module upip_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [upip_pkg::RAD_W-1:0]  i_rad,
    input  logic [upip_pkg::REM_W-1:0]  i_rem,
    input  logic [upip_pkg::ROOT_W-1:0] i_root,
    output logic [upip_pkg::RAD_W-1:0]  o_rad,
    output logic [upip_pkg::REM_W-1:0]  o_rem,
    output logic [upip_pkg::ROOT_W-1:0] o_root
);
    import upip_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  n_cur;
    logic [REM_W+1:0]  n_trial;
    logic              n_take;
    logic [REM_W+1:0]  n_diff;

    always_comb begin
        n_cur   = {i_rem, i_rad[2*K+1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_take  = n_cur >= n_trial;
        n_diff  = n_cur - n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= n_take ? n_diff[REM_W-1:0] : n_cur[REM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], n_take};
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

[rtl/upip_cordic_cell.sv]
// One rotation cell of the pipelined CORDIC chain.
module upip_cordic_cell #(
    parameter int I = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [upip_pkg::CXY_W-1:0] i_x,
    input  logic signed [upip_pkg::CXY_W-1:0] i_y,
    input  logic signed [upip_pkg::CZ_W-1:0]  i_z,
    output logic signed [upip_pkg::CXY_W-1:0] o_x,
    output logic signed [upip_pkg::CXY_W-1:0] o_y,
    output logic signed [upip_pkg::CZ_W-1:0]  o_z
);
    import upip_pkg::*;

    logic signed [CXY_W-1:0] r_x;
    logic signed [CXY_W-1:0] r_y;
    logic signed [CZ_W-1:0]  r_z;
    logic signed [CXY_W-1:0] n_dx;
    logic signed [CXY_W-1:0] n_dy;
    logic signed [CZ_W-1:0]  n_at;

    always_comb begin
        n_dx = i_y >>> I;
        n_dy = i_x >>> I;
        n_at = $signed({1'b0, ATAN_TURNS[I]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[CZ_W-1]) begin
                r_x <= i_x - n_dx;
                r_y <= i_y + n_dy;
                r_z <= i_z - n_at;
            end else begin
                r_x <= i_x + n_dx;
                r_y <= i_y - n_dy;
                r_z <= i_z + n_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

[rtl/unsteady_panel_influence_phase.sv]
// Top level of the unsteady panel influence phase pipeline.
// The input channel (i_in_valid, o_in_ready, i_in) takes one panel pair per
// beat, and the output channel (o_out_valid, i_out_ready, o_out) returns one
// coefficient beat per pair, in order.
// The registers omega and mach are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; other indexes are ignored. The user must write them only while
// no pair is in flight; the block itself does not enforce this. A new pair
// can be taken in every cycle while o_in_ready is high. A pair passes 34 cells
// of the square root chain, one cell per CORDIC rotation, and the stages of
// the phase product and the coefficient multipliers on its way to the output.
// The pipeline advances as one piece; a two entry output buffer lets it
// take one more beat while the receiver stalls, after which o_in_ready
// falls until the receiver takes a beat.
// Reset clears both registers to zero and empties the pipeline and the
// output buffer.
module unsteady_panel_influence_phase #(
    parameter int TRIG_STAGES = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  upip_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output upip_pkg::t_out o_out
);
    import upip_pkg::*;

    localparam int NC     = (TRIG_STAGES > MAX_CORDIC) ? MAX_CORDIC : TRIG_STAGES;
    localparam int NSQ    = 34;
    localparam int ST_SQ0 = 2;
    localparam int ST_ARG = ST_SQ0 + NSQ;
    localparam int ST_PP  = ST_ARG + 1;
    localparam int ST_TH  = ST_PP + 1;
    localparam int ST_CI  = ST_TH + 1;
    localparam int ST_CO0 = ST_CI + 1;
    localparam int ST_QD  = ST_CO0 + NC;
    localparam int ST_M1  = ST_QD + 1;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int NSTG   = ST_M3 + 1;

    typedef struct packed {
        logic               wake;
        logic               last;
        logic signed [15:0] nx;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [49:0] md;
        logic [32:0]        r;
        logic [1:0]         q;
    } t_side;

    logic [31:0] r_omega;
    logic [15:0] r_mach;
    logic [45:0] r_w;
    logic [31:0] r_omm;

    logic        en;
    logic        r_v [0:NSTG-1];
    t_side       r_side [0:NSTG-1];
    t_side       n_side [0:NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= '0;
            r_mach  <= '0;
            r_w     <= '0;
            r_omm   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_OMEGA) begin
                r_omega <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_MACH) begin
                r_mach <= i_cfg_data[15:0];
            end
            r_w   <= 46'((64'(r_omega) * 64'(TURN_PER_RAD_Q32)) >> 16);
            r_omm <= 32'((48'(r_omega) * 48'(r_mach)) >> 16);
        end
    end

    // Stage 0: differences, squares and the Mach term.
    logic signed [32:0] n_d [0:2];
    logic [31:0]        n_m [0:2];
    logic signed [49:0] n_md;
    logic [63:0]        r_sq [0:2];
    logic [RAD_W-1:0]   r_sum;

    always_comb begin
        n_d[0] = 33'(i_in.ctrl_x) - 33'(i_in.panel_x);
        n_d[1] = 33'(i_in.ctrl_y) - 33'(i_in.panel_y);
        n_d[2] = 33'(i_in.ctrl_z) - 33'(i_in.panel_z);
        for (int k = 0; k < 3; k++) begin
            n_m[k] = n_d[k][32] ? 32'(-n_d[k]) : n_d[k][31:0];
        end
        n_md = $signed({1'b0, r_mach}) * n_d[0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 64'(n_m[k]) * 64'(n_m[k]);
            end
            r_sum <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
        end
    end

    // Square root chain.
    logic [RAD_W-1:0]  sq_rad  [0:NSQ-1];
    logic [REM_W-1:0]  sq_rem  [0:NSQ-1];
    logic [ROOT_W-1:0] sq_root [0:NSQ-1];

    genvar g;
    generate
        for (g = 0; g < NSQ; g++) begin : g_sqrt
            if (g == 0) begin : g_first
                upip_sqrt_cell #(.K(NSQ - 1)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_rad  (r_sum),
                    .i_rem  ('0),
                    .i_root ('0),
                    .o_rad  (sq_rad[g]),
                    .o_rem  (sq_rem[g]),
                    .o_root (sq_root[g])
                );
            end else begin : g_next
                upip_sqrt_cell #(.K(NSQ - 1 - g)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_rad  (sq_rad[g-1]),
                    .i_rem  (sq_rem[g-1]),
                    .i_root (sq_root[g-1]),
                    .o_rad  (sq_rad[g]),
                    .o_rem  (sq_rem[g]),
                    .o_root (sq_root[g])
                );
            end
        end
    endgenerate

    // Phase argument and phase product.
    logic signed [50:0] n_full;
    logic signed [42:0] r_arg;
    logic [44:0]        r_p0;
    logic [43:0]        r_p1;
    logic [44:0]        r_p2;
    logic [43:0]        r_p3;
    logic               r_asgn;
    logic [63:0]        n_turns;
    logic [31:0]        r_theta;
    logic [31:0]        n_rot;
    logic signed [CZ_W-1:0] r_z;

    always_comb begin
        n_full  = $signed({2'b00, sq_root[NSQ-1][32:0], 16'h0000})
                  - 51'(r_side[ST_ARG-1].md);
        n_turns = 64'(r_p0) + (64'(r_p1) << 22) + (64'(r_p2) << 23)
                  + (64'(r_p3) << 45) - (r_asgn ? (64'(r_w) << 43) : 64'd0);
        n_rot   = r_theta + 32'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_arg   <= n_full[50:8];
            r_p0    <= 45'(r_w[22:0]) * 45'(r_arg[21:0]);
            r_p1    <= 44'(r_w[22:0]) * 44'(r_arg[42:22]);
            r_p2    <= 45'(r_w[45:23]) * 45'(r_arg[21:0]);
            r_p3    <= 44'(r_w[45:23]) * 44'(r_arg[42:22]);
            r_asgn  <= r_arg[42];
            r_theta <= 32'(-n_turns[63:32]);
            r_z     <= $signed({3'b000, n_rot[29:0]}) - 33'sd536870912;
        end
    end

    // CORDIC chain.
    logic signed [CXY_W-1:0] co_x [0:NC-1];
    logic signed [CXY_W-1:0] co_y [0:NC-1];
    logic signed [CZ_W-1:0]  co_z [0:NC-1];

    generate
        for (g = 0; g < NC; g++) begin : g_cordic
            if (g == 0) begin : g_first
                upip_cordic_cell #(.I(g)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_x   (CORDIC_INIT_Q30),
                    .i_y   ('0),
                    .i_z   (r_z),
                    .o_x   (co_x[g]),
                    .o_y   (co_y[g]),
                    .o_z   (co_z[g])
                );
            end else begin : g_next
                upip_cordic_cell #(.I(g)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_x   (co_x[g-1]),
                    .i_y   (co_y[g-1]),
                    .i_z   (co_z[g-1]),
                    .o_x   (co_x[g]),
                    .o_y   (co_y[g]),
                    .o_z   (co_z[g])
                );
            end
        end
    endgenerate

    // Side data travels with its beat; the root and quadrant join on the way.
    always_comb begin
        n_side[0].wake = i_in.func;
        n_side[0].last = i_in.last_pair;
        n_side[0].nx   = i_in.func ? 16'sd0 : i_in.normal_x;
        n_side[0].a    = i_in.func ? 32'sd0 : i_in.steady_source;
        n_side[0].b    = i_in.steady_doublet;
        n_side[0].md   = n_md;
        n_side[0].r    = '0;
        n_side[0].q    = '0;
        for (int i = 1; i < NSTG; i++) begin
            n_side[i] = r_side[i-1];
            if (i == ST_ARG) begin
                n_side[i].r = sq_root[NSQ-1][32:0];
            end
            if (i == ST_CI) begin
                n_side[i].q = n_rot[31:30];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NSTG; i++) begin
                r_side[i] <= n_side[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int i = 1; i < NSTG; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    // Quadrant rotation.
    logic signed [CXY_W-1:0] r_c;
    logic signed [CXY_W-1:0] r_s;
    logic [1:0]              n_q;

    assign n_q = r_side[ST_QD-1].q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            unique case (n_q)
                2'd0: begin r_c <= co_x[NC-1];  r_s <= co_y[NC-1];  end
                2'd1: begin r_c <= -co_y[NC-1]; r_s <= co_x[NC-1];  end
                2'd2: begin r_c <= -co_x[NC-1]; r_s <= -co_y[NC-1]; end
                default: begin r_c <= co_y[NC-1]; r_s <= -co_x[NC-1]; end
            endcase
        end
    end

    // Coefficient multipliers. Index order: Ac, As, Bc, Bs.
    logic [31:0]  n_am;
    logic [31:0]  n_bm;
    logic [31:0]  n_cm;
    logic [31:0]  n_sm;
    logic [15:0]  n_nm;
    t_side        s_m1;
    logic [33:0]  r_pm [0:3];
    logic         r_ps [0:3];
    logic [48:0]  r_omr;
    logic [32:0]  r_omn;
    logic         r_omns;

    always_comb begin
        s_m1 = r_side[ST_M1-1];
        n_am = s_m1.a[31] ? 32'(-s_m1.a) : 32'(s_m1.a);
        n_bm = s_m1.b[31] ? 32'(-s_m1.b) : 32'(s_m1.b);
        n_cm = r_c[CXY_W-1] ? 32'(-r_c) : 32'(r_c);
        n_sm = r_s[CXY_W-1] ? 32'(-r_s) : 32'(r_s);
        n_nm = s_m1.nx[15] ? 16'(-s_m1.nx) : 16'(s_m1.nx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm[0] <= 34'((64'(n_am) * 64'(n_cm)) >> 30);
            r_pm[1] <= 34'((64'(n_am) * 64'(n_sm)) >> 30);
            r_pm[2] <= 34'((64'(n_bm) * 64'(n_cm)) >> 30);
            r_pm[3] <= 34'((64'(n_bm) * 64'(n_sm)) >> 30);
            r_ps[0] <= s_m1.a[31] ^ r_c[CXY_W-1];
            r_ps[1] <= s_m1.a[31] ^ r_s[CXY_W-1];
            r_ps[2] <= s_m1.b[31] ^ r_c[CXY_W-1];
            r_ps[3] <= s_m1.b[31] ^ r_s[CXY_W-1];
            r_omr   <= 49'((65'(r_omega) * 65'(s_m1.r)) >> 16);
            r_omn   <= 33'((48'(r_omm) * 48'(n_nm)) >> 15);
            r_omns  <= s_m1.nx[15];
        end
    end

    // Cross products split in two partial products. Order: BsR, AsN, BcR, AcN.
    logic [57:0]        r_plo [0:3];
    logic [58:0]        r_phi [0:3];
    logic               r_ts  [0:3];
    logic signed [34:0] r_sv  [0:3];
    logic [33:0]        n_xm  [0:3];
    logic [48:0]        n_xb  [0:3];
    logic               n_xs  [0:3];

    always_comb begin
        n_xm[0] = r_pm[3]; n_xb[0] = r_omr;        n_xs[0] = r_ps[3];
        n_xm[1] = r_pm[1]; n_xb[1] = 49'(r_omn);   n_xs[1] = r_ps[1] ^ r_omns;
        n_xm[2] = r_pm[2]; n_xb[2] = r_omr;        n_xs[2] = r_ps[2];
        n_xm[3] = r_pm[0]; n_xb[3] = 49'(r_omn);   n_xs[3] = r_ps[0] ^ r_omns;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_plo[k] <= 58'(n_xm[k]) * 58'(n_xb[k][23:0]);
                r_phi[k] <= 59'(n_xm[k]) * 59'(n_xb[k][48:24]);
                r_ts[k]  <= n_xs[k];
                r_sv[k]  <= r_ps[k] ? -$signed({1'b0, r_pm[k]})
                                    : $signed({1'b0, r_pm[k]});
            end
        end
    end

    logic [59:0]        n_tm [0:3];
    logic signed [60:0] r_t  [0:3];
    logic signed [34:0] r_sc [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_tm[k] = 60'(r_phi[k]) + 60'(r_plo[k] >> 24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_t[k]  <= r_ts[k] ? -$signed({1'b0, n_tm[k]}) : $signed({1'b0, n_tm[k]});
                r_sc[k] <= r_sv[k];
            end
        end
    end

    function automatic logic [31:0] sat32(input logic signed [62:0] v);
        if (v > 63'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -63'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic signed [62:0] n_dr;
    logic signed [62:0] n_di;
    t_out               f_out;
    logic               f_v;

    always_comb begin
        n_dr = 63'(r_sc[2]) - 63'(r_t[0]) + 63'(r_t[1]);
        n_di = 63'(r_sc[3]) + 63'(r_t[2]) - 63'(r_t[3]);
        f_out.src_real = sat32(63'(r_sc[0]));
        f_out.src_imag = sat32(63'(r_sc[1]));
        f_out.dbl_real = sat32(n_dr);
        f_out.dbl_imag = sat32(n_di);
        f_out.last     = r_side[ST_M3].last;
        f_v            = r_v[ST_M3];
    end

    // Output register with one skid entry.
    t_out r_out;
    t_out r_skid;
    logic r_ov;
    logic r_skid_v;

    assign en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (f_v) begin
                if (!r_ov || i_out_ready) begin
                    r_out <= f_out;
                    r_ov  <= 1'b1;
                end else begin
                    r_skid   <= f_out;
                    r_skid_v <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_out    <= r_skid;
            r_skid_v <= 1'b0;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("Skid entry holds a beat while the output register is empty.");
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_ov && !i_out_ready && f_v))
        else $error("Skid entry filled without a stalled output.");
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_ready) |=> (!r_skid_v && r_ov))
        else $error("Skid entry did not drain into the output register.");
`endif
endmodule
